// ----- rtl/swcfs_pkg.sv -----
// Package for the set/way cache flush sequencer.
// Holds the sequencer phases, command and operation codes, and the result type.
// No dependencies.
package swcfs_pkg;

  // Highest number of cache levels taken from the level ID word
  localparam int unsigned MaxLevels = 7;

  // Field widths of the level ID and size ID words
  localparam int unsigned LevelW = 3;
  localparam int unsigned WayW   = 10;
  localparam int unsigned SetW   = 15;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned WbitsW = 4;
  localparam int unsigned DataW  = 32;

  // Input commands
  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_GEOMETRY = 2'd1,
    CMD_NEXT     = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  // Kinds of result operation
  typedef enum logic [2:0] {
    KIND_SELECT = 3'd0,
    KIND_SETWAY = 3'd1,
    KIND_ICACHE = 3'd2,
    KIND_BPRED  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_GEOM = 3'd1,
    PH_SWEEP     = 3'd2,
    PH_SELECT    = 3'd3,
    PH_ICACHE    = 3'd4,
    PH_BPRED     = 3'd5,
    PH_DONE      = 3'd6
  } phase_e;

  // One result item
  typedef struct packed {
    kind_e             op_kind;
    logic [DataW-1:0]  op_value;
    logic              last;
  } result_t;

  // Register address of the level ID word (word index)
  localparam logic RegLevelId = 1'b0;

endpackage

// ----- rtl/set_way_cache_flush_sequencer.sv -----
// Top level of the set/way cache flush sequencer.
// Uses swcfs_pkg for phase and operation codes and the result type.
//
// The sequencer takes one command transfer per clock cycle while its output buffer has
// room, and registers its result, if the command gives one, in that buffer for the master side.
// A start command scans the configured level ID word for the first data or
// unified level and asks for it to be selected; the host answers with that
// level's size ID word, and each pull then returns one set/way operand
// (ways and sets counting down), followed after the last level by an
// instruction-cache invalidate, a branch-predictor invalidate and a done item
// marked with tlast. A two-entry output buffer keeps the slave side ready
// while one result waits; s_axis_tready drops only when both entries are full.
module set_way_cache_flush_sequencer #(
  parameter int unsigned MaxLevels = swcfs_pkg::MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] geometry_word
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // Operation stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] op_value
  output logic [2:0]  m_axis_tuser,   // [2:0] op_kind
  output logic        m_axis_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DataW = swcfs_pkg::DataW;

  // Configuration register
  logic [DataW-1:0] level_id_q;

  // Sequencer state
  swcfs_pkg::phase_e                 phase_q, phase_d;
  logic [swcfs_pkg::LevelW-1:0]      level_q, level_d;
  logic [swcfs_pkg::WayW-1:0]        way_q, way_d;
  logic [swcfs_pkg::SetW-1:0]        set_q, set_d;
  logic [swcfs_pkg::SetW-1:0]        reload_q, reload_d;
  logic [swcfs_pkg::ShiftW-1:0]      shift_q, shift_d;
  logic [swcfs_pkg::WbitsW-1:0]      wbits_q, wbits_d;

  // Output buffer: head entry and skid entry
  swcfs_pkg::result_t head_q, skid_q, res;
  logic               head_valid_q, skid_valid_q;
  logic               has_res, accept, pop, push;

  swcfs_pkg::cmd_e    cmd;
  logic               seek_found;
  logic [swcfs_pkg::LevelW-1:0] seek_level;
  logic [swcfs_pkg::LevelW:0]   seek_from;
  logic [MaxLevels-1:0]         dcache_mask;
  logic [swcfs_pkg::WbitsW-1:0] ceil_bits;
  logic [swcfs_pkg::WayW-1:0]   geo_ways;
  logic [DataW+swcfs_pkg::WayW-1:0] way_wide;
  logic [DataW-1:0]             set_field;
  logic [DataW-1:0]             setway_value;

  // APB port: single register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == swcfs_pkg::RegLevelId) ? level_id_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_id_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == swcfs_pkg::RegLevelId)) begin
      level_id_q <= pwdata;
    end
  end

  // Handshakes
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = head_valid_q && m_axis_tready;
  assign push          = accept && has_res;
  assign cmd           = swcfs_pkg::cmd_e'(s_axis_tuser);

  // Levels holding a data or unified cache
  always_comb begin
    for (int unsigned l = 0; l < MaxLevels; l++) begin
      dcache_mask[l] = (level_id_q[3*l+1 +: 2] != 2'b00) && (l >= seek_from);
    end
  end

  // First such level at or after the scan start
  always_comb begin
    seek_found = 1'b0;
    seek_level = '0;
    for (int l = int'(MaxLevels) - 1; l >= 0; l--) begin
      if (dcache_mask[l]) begin
        seek_found = 1'b1;
        seek_level = swcfs_pkg::LevelW'(l);
      end
    end
  end

  // Start scans from level zero, the end of a sweep from the next level
  assign seek_from = (cmd == swcfs_pkg::CMD_START) ? '0 : ({1'b0, level_q} + 1'b1);

  // Way count is field plus one, so its ceiling log2 is the bit length of the field
  assign geo_ways = s_axis_tdata[3 +: swcfs_pkg::WayW];
  always_comb begin
    ceil_bits = '0;
    for (int unsigned b = 0; b < swcfs_pkg::WayW; b++) begin
      if (geo_ways[b]) begin
        ceil_bits = swcfs_pkg::WbitsW'(b + 1);
      end
    end
  end

  // Set/way operand: way in the top bits, set above the line offset, level below
  assign way_wide     = {way_q, {DataW{1'b0}}} >> wbits_q;
  assign set_field    = {{(DataW-swcfs_pkg::SetW){1'b0}}, set_q} << shift_q;
  assign setway_value = way_wide[DataW-1:0] | set_field
                      | {{(DataW-swcfs_pkg::LevelW-1){1'b0}}, level_q, 1'b0};

  // Next state and result for the accepted command
  always_comb begin
    phase_d  = phase_q;
    level_d  = level_q;
    way_d    = way_q;
    set_d    = set_q;
    reload_d = reload_q;
    shift_d  = shift_q;
    wbits_d  = wbits_q;
    has_res  = 1'b0;
    res.op_kind  = swcfs_pkg::KIND_SELECT;
    res.op_value = '0;
    res.last     = 1'b0;
    case (cmd)
      swcfs_pkg::CMD_START: begin
        if (seek_found) begin
          level_d      = seek_level;
          phase_d      = swcfs_pkg::PH_WAIT_GEOM;
          has_res      = 1'b1;
          res.op_kind  = swcfs_pkg::KIND_SELECT;
          res.op_value = {{(DataW-swcfs_pkg::LevelW-1){1'b0}}, seek_level, 1'b0};
        end else begin
          phase_d = swcfs_pkg::PH_ICACHE;
        end
      end
      swcfs_pkg::CMD_GEOMETRY: begin
        if (phase_q == swcfs_pkg::PH_WAIT_GEOM) begin
          shift_d  = {1'b0, s_axis_tdata[2:0]} + 4'd4;
          way_d    = geo_ways;
          wbits_d  = ceil_bits;
          reload_d = s_axis_tdata[13 +: swcfs_pkg::SetW];
          set_d    = s_axis_tdata[13 +: swcfs_pkg::SetW];
          phase_d  = swcfs_pkg::PH_SWEEP;
        end
      end
      swcfs_pkg::CMD_NEXT: begin
        case (phase_q)
          swcfs_pkg::PH_SWEEP: begin
            has_res      = 1'b1;
            res.op_kind  = swcfs_pkg::KIND_SETWAY;
            res.op_value = setway_value;
            if (set_q != '0) begin
              set_d = set_q - 1'b1;
            end else if (way_q != '0) begin
              way_d = way_q - 1'b1;
              set_d = reload_q;
            end else if (seek_found) begin
              level_d = seek_level;
              phase_d = swcfs_pkg::PH_SELECT;
            end else begin
              phase_d = swcfs_pkg::PH_ICACHE;
            end
          end
          swcfs_pkg::PH_SELECT: begin
            phase_d      = swcfs_pkg::PH_WAIT_GEOM;
            has_res      = 1'b1;
            res.op_kind  = swcfs_pkg::KIND_SELECT;
            res.op_value = {{(DataW-swcfs_pkg::LevelW-1){1'b0}}, level_q, 1'b0};
          end
          swcfs_pkg::PH_ICACHE: begin
            phase_d     = swcfs_pkg::PH_BPRED;
            has_res     = 1'b1;
            res.op_kind = swcfs_pkg::KIND_ICACHE;
          end
          swcfs_pkg::PH_BPRED: begin
            phase_d     = swcfs_pkg::PH_DONE;
            has_res     = 1'b1;
            res.op_kind = swcfs_pkg::KIND_BPRED;
          end
          swcfs_pkg::PH_DONE: begin
            phase_d     = swcfs_pkg::PH_IDLE;
            has_res     = 1'b1;
            res.op_kind = swcfs_pkg::KIND_DONE;
            res.last    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= swcfs_pkg::PH_IDLE;
      level_q  <= '0;
      way_q    <= '0;
      set_q    <= '0;
      reload_q <= '0;
      shift_q  <= '0;
      wbits_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      level_q  <= level_d;
      way_q    <= way_d;
      set_q    <= set_d;
      reload_q <= reload_d;
      shift_q  <= shift_d;
      wbits_q  <= wbits_d;
    end
  end

  // Output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      head_valid_q <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (!head_valid_q) begin
      head_valid_q <= push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
        skid_q <= res;
      end else begin
        head_q <= res;
      end
    end else if (!head_valid_q) begin
      head_q <= res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = head_valid_q;
  assign m_axis_tdata  = head_q.op_value;
  assign m_axis_tuser  = head_q.op_kind;
  assign m_axis_tlast  = head_q.last;

endmodule

// ----- verif/swcfs_checker.sv -----
// Checker for the set/way cache flush sequencer: watches the command, operation
// and configuration channels, predicts every operation and compares it.
// Depends on swcfs_pkg for the command, kind and phase codes and the result type.
module swcfs_checker
  import swcfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_ops
);

  localparam logic [2:0] LevelIdAddr = {RegLevelId, 2'b00};

  // Shadow copy of the register and of the sequencer state.
  logic [31:0]       level_id_reg;
  phase_e            seq_phase;
  logic [2:0]        sweep_level;
  logic [WayW-1:0]   way_left;
  logic [SetW-1:0]   set_left;
  logic [SetW-1:0]   set_start;
  logic [ShiftW-1:0] set_shift;
  logic [WbitsW-1:0] way_width;

  // Operations predicted but not yet seen on the master side, oldest first.
  result_t flush_ops_due[$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic queue_op(input kind_e kind, input logic [31:0] value, input logic last);
    result_t op;
    op.op_kind  = kind;
    op.op_value = value;
    op.last     = last;
    flush_ops_due.push_back(op);
  endtask

  // Number of bits needed to hold a way index, rounded up.
  function automatic logic [WbitsW-1:0] way_index_bits(input logic [WayW:0] ways);
    int unsigned b;
    b = 0;
    while (b < 31 && (32'd1 << b) < ways) b++;
    return WbitsW'(b);
  endfunction

  // Find the first data or unified level at or after the given one.
  task automatic find_level(input int from);
    bit found;
    found = 1'b0;
    for (int lv = from; lv < int'(MaxLevels); lv++) begin
      if (!found && level_id_reg[3*lv +: 3] >= 3'd2) begin
        found       = 1'b1;
        sweep_level = 3'(lv);
      end
    end
    seq_phase = found ? PH_SELECT : PH_ICACHE;
  endtask

  // Advance the shadow state by one accepted command and queue its operation.
  task automatic predict_command(input cmd_e cmd, input logic [31:0] geo);
    logic [WayW:0] ways;
    logic [31:0]   value;
    case (cmd)
      CMD_START: begin
        find_level(0);
        if (seq_phase == PH_SELECT) begin
          seq_phase = PH_WAIT_GEOM;
          queue_op(KIND_SELECT, {28'd0, sweep_level, 1'b0}, 1'b0);
        end
      end
      CMD_GEOMETRY: begin
        if (seq_phase == PH_WAIT_GEOM) begin
          set_shift = ShiftW'(geo[2:0]) + ShiftW'(4);
          ways      = {1'b0, geo[12:3]} + 1'b1;
          way_left  = geo[12:3];
          way_width = way_index_bits(ways);
          set_start = geo[27:13];
          set_left  = geo[27:13];
          seq_phase = PH_SWEEP;
        end
      end
      CMD_NEXT: begin
        case (seq_phase)
          PH_SWEEP: begin
            value = (32'(set_left) << set_shift) | {28'd0, sweep_level, 1'b0};
            // A single way leaves the way field empty.
            if (way_width != '0) value |= 32'(way_left) << (32 - int'(way_width));
            queue_op(KIND_SETWAY, value, 1'b0);
            if (set_left != '0) begin
              set_left--;
            end else if (way_left != '0) begin
              way_left--;
              set_left = set_start;
            end else begin
              find_level(int'(sweep_level) + 1);
            end
          end
          PH_SELECT: begin
            seq_phase = PH_WAIT_GEOM;
            queue_op(KIND_SELECT, {28'd0, sweep_level, 1'b0}, 1'b0);
          end
          PH_ICACHE: begin
            seq_phase = PH_BPRED;
            queue_op(KIND_ICACHE, '0, 1'b0);
          end
          PH_BPRED: begin
            seq_phase = PH_DONE;
            queue_op(KIND_BPRED, '0, 1'b0);
          end
          PH_DONE: begin
            seq_phase = PH_IDLE;
            queue_op(KIND_DONE, '0, 1'b1);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Compare one operation transfer with the oldest prediction.
  task automatic check_op();
    result_t want;
    if (flush_ops_due.size() == 0) begin
      report_mismatch($sformatf("unexpected operation kind %0d value %h",
                                m_axis_tuser, m_axis_tdata));
    end else begin
      want = flush_ops_due.pop_front();
      if (m_axis_tuser !== want.op_kind)
        report_mismatch($sformatf("op_kind %0d, predicted %0d", m_axis_tuser, want.op_kind));
      if (m_axis_tdata !== want.op_value)
        report_mismatch($sformatf("op_value %h, predicted %h", m_axis_tdata, want.op_value));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("last %b, predicted %b", m_axis_tlast, want.last));
    end
  endtask

  // Operations are checked before the command of the same edge is predicted,
  // since an operation always stems from an earlier command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_id_reg = '0;
      seq_phase    = PH_IDLE;
      sweep_level  = '0;
      way_left     = '0;
      set_left     = '0;
      set_start    = '0;
      set_shift    = '0;
      way_width    = '0;
      flush_ops_due.delete();
      fail_count   = 0;
      pending_ops  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_op();
      if (psel && penable && pready && paddr == LevelIdAddr) begin
        if (pwrite) begin
          level_id_reg = pwdata;
        end else if (prdata !== level_id_reg) begin
          report_mismatch($sformatf("level ID read %h, written %h", prdata, level_id_reg));
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_command(cmd_e'(s_axis_tuser), s_axis_tdata);
      pending_ops = flush_ops_due.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the set/way cache flush sequencer: clock, reset, command
// and configuration stimulus, random back-pressure and the final verdict.
// Depends on swcfs_pkg, set_way_cache_flush_sequencer and swcfs_checker.
module tb;
  import swcfs_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = CMD_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_ops;
  int commands_sent  = 0;
  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;
  int ready_hold     = 0;

  always #5 clk_i = ~clk_i;

  set_way_cache_flush_sequencer u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  swcfs_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending_ops
  );

  // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
  always @(negedge clk_i) begin
    if (!sink_stalls_on) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          m_axis_tready <= 1'b0;
          ready_hold    <= $urandom_range(10, 40);
        end
        1, 2, 3, 4, 5, 6: begin
          m_axis_tready <= 1'b0;
          ready_hold    <= $urandom_range(0, 2);
        end
        default: begin
          m_axis_tready <= 1'b1;
          ready_hold    <= $urandom_range(0, 15);
        end
      endcase
    end
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // One command transfer; entered and left at a falling edge.
  task automatic send_command(input cmd_e cmd, input logic [31:0] geo);
    int gap;
    gap = 0;
    if (src_gaps_on) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(8, 30);
        1, 2, 3: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= geo;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    commands_sent++;
  endtask

  // Hold off until every predicted operation has arrived and the block is still.
  task automatic drain_operations();
    s_axis_tvalid <= 1'b0;
    while (pending_ops != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the level ID word, then read it back in a following transfer.
  task automatic configure_levels(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegLevelId, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Size ID word with random content, most of them describing small caches.
  function automatic logic [31:0] random_geometry();
    logic [31:0] g;
    g = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      g[12:3]  = $urandom_range(0, 5);
      g[27:13] = $urandom_range(0, 5);
    end
    return g;
  endfunction

  // A well-formed flush sequence with random geometry, sometimes cut short
  // and sprinkled with stray commands.
  task automatic run_flush_sequence();
    logic [31:0] g;
    int          levels;
    int          pulls;
    bit          cut;
    send_command(CMD_START, $urandom);
    levels = $urandom_range(1, MaxLevels);
    for (int k = 0; k < levels; k++) begin
      g = random_geometry();
      send_command(CMD_GEOMETRY, g);
      pulls = (int'(g[12:3]) + 1) * (int'(g[27:13]) + 1);
      cut   = (pulls > 64) || ($urandom_range(0, 19) == 0);
      if (cut) pulls = $urandom_range(1, 12);
      repeat (pulls) begin
        if ($urandom_range(0, 29) == 0) send_command(cmd_e'($urandom_range(0, 3)), $urandom);
        send_command(CMD_NEXT, $urandom);
      end
      if (cut) return;
      // Either the select of the next level or the instruction-cache invalidate.
      send_command(CMD_NEXT, $urandom);
    end
    repeat ($urandom_range(2, 4)) send_command(CMD_NEXT, $urandom);
  endtask

  initial begin
    logic [31:0] level_settings [6];
    int          phase_start;
    level_settings = '{32'hFFFF_FFFF, 32'h0000_0102, 32'h0008_0000,
                       32'h0000_0000, 32'hFFE0_0000, 32'h0000_0000};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Level 0 data, level 1 absent, level 2 unified.
    configure_levels(32'h0000_0102);
    // Commands that must be ignored while idle.
    send_command(CMD_NEXT, 32'hFFFF_FFFF);
    send_command(CMD_GEOMETRY, 32'h0000_0000);
    send_command(CMD_UNUSED, 32'h5A5A_A5A5);
    // Start, a pull while geometry is awaited, and a restart.
    send_command(CMD_START, 32'h0);
    send_command(CMD_NEXT, 32'h0);
    send_command(CMD_START, 32'h0);
    // One way and two sets: the way field stays empty.
    send_command(CMD_GEOMETRY, 32'h0000_2000);
    send_command(CMD_NEXT, 32'h0);
    send_command(CMD_NEXT, 32'h0);
    // Geometry while a select is still to be pulled is ignored.
    send_command(CMD_GEOMETRY, 32'h0000_0008);
    send_command(CMD_NEXT, 32'h0);
    // Largest line, ways and sets, then a restart in the middle of the sweep.
    send_command(CMD_GEOMETRY, 32'hFFFF_FFFF);
    send_command(CMD_NEXT, 32'h0);
    send_command(CMD_NEXT, 32'h0);
    send_command(CMD_START, 32'h0);
    // Three ways, one set.
    send_command(CMD_GEOMETRY, 32'h0000_0013);
    repeat (3) send_command(CMD_NEXT, 32'h0);
    send_command(CMD_NEXT, 32'h0);
    // Smallest geometry on the last level, then the closing operations.
    send_command(CMD_GEOMETRY, 32'h0000_0000);
    repeat (4) send_command(CMD_NEXT, 32'h0);
    send_command(CMD_NEXT, 32'h0);

    // No cache level at all: start yields nothing and pulls close the sequence.
    drain_operations();
    configure_levels(32'h0000_0000);
    send_command(CMD_START, 32'h0);
    repeat (4) send_command(CMD_NEXT, 32'h0);

    // Random sequences under several level ID settings, the first without idling.
    for (int p = 0; p < 6; p++) begin
      drain_operations();
      configure_levels((p == 3 || p == 5) ? 32'($urandom) : level_settings[p]);
      src_gaps_on    = (p != 0);
      sink_stalls_on = (p != 0);
      phase_start    = commands_sent;
      while (commands_sent - phase_start < 40) run_flush_sequence();
    end

    drain_operations();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- set_way_cache_flush_sequencer.f -----
rtl/swcfs_pkg.sv
rtl/set_way_cache_flush_sequencer.sv
verif/swcfs_checker.sv
verif/tb.sv
